/* rtl/core/matrix_inverse_4x4_assert.svh */
// Assertion macros for the 4x4 matrix inverse block.
`ifndef MATRIX_INVERSE_4X4_ASSERT_SVH
`define MATRIX_INVERSE_4X4_ASSERT_SVH
`ifndef SYNTHESIS
`define MI4_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define MI4_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MI4_ASSERT_IMP(lbl, ante, cons, msg)
`define MI4_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

/* rtl/core/mi4_pkg.sv */
// Types, constants and helper functions for the 4x4 matrix inverse block.
package mi4_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ELEM_W    = 32;
  localparam int ACC_W     = 136;
  localparam int LIMB_W    = 32;
  localparam int NLIMB     = 5;
  localparam int PAD_W     = NLIMB * LIMB_W;
  localparam int SHIFT     = 2 * FRAC_BITS + 1;
  localparam int NUM_W     = ACC_W + SHIFT;
  localparam int CNT_W     = $clog2(NUM_W);
  localparam int PROD_W    = ELEM_W + ELEM_W + 1;

  typedef struct packed {
    logic signed [ELEM_W-1:0] elem_0;
    logic signed [ELEM_W-1:0] elem_1;
    logic signed [ELEM_W-1:0] elem_2;
    logic signed [ELEM_W-1:0] elem_3;
  } in_t;

  typedef struct packed {
    logic [1:0]               row_index;
    logic signed [ELEM_W-1:0] inv_0;
    logic signed [ELEM_W-1:0] inv_1;
    logic signed [ELEM_W-1:0] inv_2;
    logic signed [ELEM_W-1:0] inv_3;
    logic                     singular;
    logic                     saturated;
    logic                     last_row;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LA, ST_MAB, ST_TP, ST_TA, ST_ADJ_WR, ST_DP, ST_DA,
    ST_DCHK, ST_DIV_GO, ST_DIV_WAIT, ST_EMIT
  } state_t;

  typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_ROUND, DV_DONE} div_state_t;

  typedef struct packed {
    logic                    start;
    logic signed [ACC_W-1:0] num;
    logic signed [ACC_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [ELEM_W-1:0] quo;
  } div_rsp_t;

  // element address of factor f of cofactor term for adjugate entry ent
  function automatic logic [3:0] term_addr(logic [3:0] ent, logic [2:0] term, logic [1:0] f);
    logic [1:0] k;
    logic [1:0] r;
    logic [1:0] c;
    unique case (term)
      3'd0: k = f;
      3'd1: k = (f == 2'd2) ? 2'd0 : f + 2'd1;
      3'd2: k = (f == 2'd0) ? 2'd2 : f - 2'd1;
      3'd3: k = 2'd2 - f;
      3'd4: k = (f == 2'd0) ? 2'd1 : ((f == 2'd1) ? 2'd0 : 2'd2);
      3'd5: k = (f == 2'd0) ? 2'd0 : ((f == 2'd1) ? 2'd2 : 2'd1);
      default: k = f;
    endcase
    r = f + {1'b0, (f >= ent[1:0])};
    c = k + {1'b0, (k >= ent[3:2])};
    return {r, c};
  endfunction

endpackage

/* rtl/core/mi4_div.sv */
// Bit-serial restoring divider with rounding and saturation to 32 bits.
module mi4_div (
  input  logic              clk,
  input  logic              rst_n,
  input  mi4_pkg::div_req_t req,
  output mi4_pkg::div_rsp_t rsp
);
  import mi4_pkg::*;

  div_state_t            state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic [NUM_W-1:0]      nm_r;
  logic [NUM_W-1:0]      q_r;
  logic [ACC_W-1:0]      rem_r;
  logic [ACC_W-1:0]      d_r;
  logic                  neg_r;
  logic                  sat_r;
  logic [ELEM_W-1:0]     quo_r;

  logic [ACC_W-1:0]      num_abs;
  logic [ACC_W-1:0]      den_abs;
  logic [ACC_W:0]        remsh;
  logic [ACC_W+1:0]      diff;
  logic                  ge;
  logic [NUM_W:0]        qinc;
  logic [NUM_W-1:0]      qr;
  logic                  sat;
  logic [ELEM_W-1:0]     quo;

  always_comb begin
    num_abs = req.num[ACC_W-1] ? ACC_W'(-req.num) : ACC_W'(req.num);
    den_abs = req.den[ACC_W-1] ? ACC_W'(-req.den) : ACC_W'(req.den);
    remsh   = {rem_r, nm_r[NUM_W-1]};
    diff    = {1'b0, remsh} - {2'b00, d_r};
    ge      = !diff[ACC_W+1];
    qinc    = {1'b0, q_r} + (NUM_W+1)'(1);
    qr      = qinc[NUM_W:1];
    if (neg_r) begin
      sat = (qr[NUM_W-1:32] != '0) || (qr[31] && (qr[30:0] != '0));
    end else begin
      sat = (qr[NUM_W-1:31] != '0);
    end
    if (sat) begin
      quo = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      quo = neg_r ? (32'd0 - qr[31:0]) : qr[31:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      DV_IDLE:  if (req.start) state_nxt = DV_RUN;
      DV_RUN:   if (cnt_r == '0) state_nxt = DV_ROUND;
      DV_ROUND: state_nxt = DV_DONE;
      DV_DONE:  state_nxt = DV_IDLE;
      default:  state_nxt = DV_IDLE;
    endcase
  end

  always_comb begin
    rsp.done = (state_r == DV_DONE);
    rsp.sat  = sat_r;
    rsp.quo  = quo_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DV_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      DV_IDLE: begin
        nm_r  <= {num_abs, SHIFT'(0)};
        d_r   <= den_abs;
        neg_r <= req.num[ACC_W-1] ^ req.den[ACC_W-1];
        rem_r <= '0;
        q_r   <= '0;
        cnt_r <= CNT_W'(NUM_W - 1);
      end
      DV_RUN: begin
        rem_r <= ge ? diff[ACC_W-1:0] : remsh[ACC_W-1:0];
        q_r   <= {q_r[NUM_W-2:0], ge};
        nm_r  <= {nm_r[NUM_W-2:0], 1'b0};
        cnt_r <= cnt_r - CNT_W'(1);
      end
      DV_ROUND: begin
        sat_r <= sat;
        quo_r <= quo;
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/core/matrix_inverse_4x4.sv */
// Top level of the 4x4 matrix inverse: row store, cofactor sequencer, output stage.
//
//   channel | direction | ports                       | one request
//   in      | input     | in_valid, in_stall, in_data  | one matrix row
//   out     | output    | out_valid, out_stall, out_data | one inverse row
//
// Rows 0..2 are only stored. Row 3 starts the work: 16 adjugate entries and the
// determinant on one 33x32 multiplier, then, unless the determinant is zero,
// 16 divisions on the bit-serial divider.
// Reset clears the sequencer, row count and output valid; the store needs none.
// in_stall is high from the fourth row until the last result row is loaded;
// a stalled output row holds the sequencer before the next row is loaded.
module matrix_inverse_4x4 (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  mi4_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output mi4_pkg::out_t out_data
);
  import mi4_pkg::*;
  `include "matrix_inverse_4x4_assert.svh"

  state_t                   state_r, state_nxt;
  logic [1:0]               rows_loaded_r;
  logic signed [ELEM_W-1:0] mat_r [16];
  logic signed [ACC_W-1:0]  adj_r [16];
  logic [3:0]               ent_r;
  logic [2:0]               term_r;
  logic [2:0]               lmb_r;
  logic [1:0]               dj_r;
  logic signed [ELEM_W-1:0] ea_r;
  logic [63:0]              p_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic                     singular_r;
  logic                     rsat_r;
  logic [ELEM_W-1:0]        row_r [4];
  logic                     out_valid_r;
  out_t                     out_r;

  logic                     in_acc;
  logic                     out_free;
  logic [3:0]               rd_addr;
  logic signed [ELEM_W-1:0] elem_rd;
  logic [3:0]               adj_addr;
  logic [PAD_W-1:0]         adj_pad;
  logic [LIMB_W-1:0]        adj_limb;
  logic signed [32:0]       op_a;
  logic signed [PROD_W-1:0] mul;
  logic signed [ACC_W-1:0]  add_val;
  logic                     term_sub;
  div_req_t                 dreq;
  div_rsp_t                 drsp;

  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  mi4_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .rsp   (drsp)
  );

  always_comb begin
    rd_addr  = term_addr(ent_r, term_r, 2'd2);
    adj_addr = ent_r;
    op_a     = {1'b0, p_r[31:0]};
    unique case (state_r)
      ST_LA:  rd_addr = term_addr(ent_r, term_r, 2'd0);
      ST_MAB: rd_addr = term_addr(ent_r, term_r, 2'd1);
      ST_DP:  rd_addr = {2'b00, dj_r};
      default: rd_addr = term_addr(ent_r, term_r, 2'd2);
    endcase
    if (state_r == ST_DP) begin
      adj_addr = {dj_r, 2'b00};
    end
    elem_rd  = mat_r[rd_addr];
    adj_pad  = PAD_W'(unsigned'(adj_r[adj_addr]));
    adj_limb = LIMB_W'(adj_pad >> {lmb_r, 5'b0});
    unique case (state_r)
      ST_MAB: op_a = {ea_r[ELEM_W-1], ea_r};
      ST_DP:  op_a = {1'b0, adj_limb};
      default: op_a = lmb_r[0] ? {p_r[63], p_r[63:32]} : {1'b0, p_r[31:0]};
    endcase
    mul      = PROD_W'(op_a) * PROD_W'(elem_rd);
    add_val  = ACC_W'(prod_r) <<< {lmb_r, 5'b0};
    term_sub = (term_r >= 3'd3) ^ ent_r[2] ^ ent_r[0];
    dreq.start = (state_r == ST_DIV_GO);
    dreq.num   = adj_r[adj_addr];
    dreq.den   = acc_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc && rows_loaded_r == 2'd3) state_nxt = ST_LA;
      ST_LA:     state_nxt = ST_MAB;
      ST_MAB:    state_nxt = ST_TP;
      ST_TP:     state_nxt = ST_TA;
      ST_TA: begin
        if (lmb_r[0] && term_r == 3'd5) state_nxt = ST_ADJ_WR;
        else if (lmb_r[0]) state_nxt = ST_LA;
        else state_nxt = ST_TP;
      end
      ST_ADJ_WR: state_nxt = (ent_r == 4'd15) ? ST_DP : ST_LA;
      ST_DP:     state_nxt = ST_DA;
      ST_DA:     state_nxt = (lmb_r == 3'd4 && dj_r == 2'd3) ? ST_DCHK : ST_DP;
      ST_DCHK:   state_nxt = (acc_r == '0) ? ST_EMIT : ST_DIV_GO;
      ST_DIV_GO: state_nxt = ST_DIV_WAIT;
      ST_DIV_WAIT: begin
        if (drsp.done) state_nxt = (ent_r[1:0] == 2'd3) ? ST_EMIT : ST_DIV_GO;
      end
      ST_EMIT: begin
        if (out_free) begin
          if (ent_r[3:2] == 2'd3) state_nxt = ST_IDLE;
          else state_nxt = singular_r ? ST_EMIT : ST_DIV_GO;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      rows_loaded_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc) rows_loaded_r <= rows_loaded_r + 2'd1;
      if (state_r == ST_EMIT && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < 16; e++) begin
      if (in_acc && rows_loaded_r == 2'(e / 4)) begin
        unique case (e % 4)
          0: mat_r[e] <= in_data.elem_0;
          1: mat_r[e] <= in_data.elem_1;
          2: mat_r[e] <= in_data.elem_2;
          default: mat_r[e] <= in_data.elem_3;
        endcase
      end
    end
    unique case (state_r)
      ST_IDLE: begin
        ent_r  <= '0;
        term_r <= '0;
        lmb_r  <= '0;
        acc_r  <= '0;
      end
      ST_LA: begin
        ea_r  <= elem_rd;
        lmb_r <= '0;
      end
      ST_MAB: p_r <= mul[63:0];
      ST_TP:  prod_r <= mul;
      ST_TA: begin
        acc_r <= term_sub ? acc_r - add_val : acc_r + add_val;
        lmb_r <= 3'd1;
        if (lmb_r[0]) term_r <= term_r + 3'd1;
      end
      ST_ADJ_WR: begin
        adj_r[ent_r] <= acc_r;
        acc_r  <= '0;
        term_r <= '0;
        ent_r  <= ent_r + 4'd1;
        dj_r   <= '0;
        lmb_r  <= '0;
      end
      ST_DP: prod_r <= mul;
      ST_DA: begin
        acc_r <= acc_r + add_val;
        if (lmb_r == 3'd4) begin
          lmb_r <= '0;
          dj_r  <= dj_r + 2'd1;
        end else begin
          lmb_r <= lmb_r + 3'd1;
        end
      end
      ST_DCHK: begin
        singular_r <= (acc_r == '0);
        ent_r      <= '0;
        rsat_r     <= 1'b0;
        for (int c = 0; c < 4; c++) row_r[c] <= '0;
      end
      ST_DIV_WAIT: begin
        if (drsp.done) begin
          row_r[ent_r[1:0]] <= drsp.quo;
          rsat_r <= rsat_r | drsp.sat;
          if (ent_r[1:0] != 2'd3) ent_r <= ent_r + 4'd1;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_r.row_index <= ent_r[3:2];
          out_r.inv_0     <= row_r[0];
          out_r.inv_1     <= row_r[1];
          out_r.inv_2     <= row_r[2];
          out_r.inv_3     <= row_r[3];
          out_r.singular  <= singular_r;
          out_r.saturated <= rsat_r;
          out_r.last_row  <= (ent_r[3:2] == 2'd3);
          rsat_r <= 1'b0;
          ent_r  <= {ent_r[3:2] + 2'd1, 2'b00};
        end
      end
      default: begin
      end
    endcase
  end

  `MI4_ASSERT_IMP(a_last_row, out_valid, out_data.last_row == (out_data.row_index == 2'd3), "last_row flag does not match row_index")
  `MI4_ASSERT_IMP(a_singular_zero, out_valid && out_data.singular, out_data.inv_0 == '0 && out_data.inv_1 == '0 && out_data.inv_2 == '0 && out_data.inv_3 == '0 && !out_data.saturated, "singular row is not zero")
  `MI4_ASSERT_NXT(a_start, in_valid && !in_stall && rows_loaded_r == 2'd3, state_r == ST_LA, "fourth row did not start the cofactor sequence")

endmodule

/* dv/matrix_inverse_4x4_tb.sv */
// Testbench for matrix_inverse_4x4: streams matrix rows, predicts inverse rows, checks them.
module matrix_inverse_4x4_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mi4_pkg::*;

  typedef logic signed [255:0] wide_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  in_t row_q[$];
  out_t inverse_q[$];
  logic signed [31:0] held[16];
  int rows_in = 0;
  int rows_out = 0;
  int fail_cnt = 0;
  int cycle_cnt = 0;
  int quiet_cnt = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit calm;

  matrix_inverse_4x4 dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  assign calm = (cycle_cnt % 30000) < 8000;

  function automatic wide_t cofactor3(input int sr, input int sc);
    int r[3];
    int c[3];
    int n;
    wide_t a[3][3];
    n = 0;
    for (int k = 0; k < 4; k++) if (k != sr) begin r[n] = k; n++; end
    n = 0;
    for (int k = 0; k < 4; k++) if (k != sc) begin c[n] = k; n++; end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) a[i][j] = held[r[i] * 4 + c[j]];
    return a[0][0] * a[1][1] * a[2][2] + a[0][1] * a[1][2] * a[2][0]
         + a[0][2] * a[1][0] * a[2][1] - a[0][2] * a[1][1] * a[2][0]
         - a[0][1] * a[1][0] * a[2][2] - a[0][0] * a[1][2] * a[2][1];
  endfunction

  task automatic predict_inverse();
    wide_t adj[4][4];
    wide_t det;
    logic [255:0] num;
    logic [255:0] den;
    logic [255:0] quo;
    logic [255:0] lim;
    logic [31:0] val[4];
    bit neg;
    bit sat;
    out_t res;
    det = '0;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        adj[i][j] = cofactor3(j, i);
        if ((i + j) % 2) adj[i][j] = -adj[i][j];
      end
    for (int j = 0; j < 4; j++) det = det + adj[j][0] * wide_t'(held[j]);
    for (int i = 0; i < 4; i++) begin
      sat = 1'b0;
      for (int j = 0; j < 4; j++) begin
        if (det == 0) begin
          val[j] = '0;
        end else begin
          neg = (adj[i][j] < 0) != (det < 0);
          num = (adj[i][j] < 0) ? -adj[i][j] : adj[i][j];
          den = (det < 0) ? -det : det;
          quo = ((num << (2 * FRAC_BITS + 1)) / den + 1) >> 1;
          lim = neg ? 256'h8000_0000 : 256'h7fff_ffff;
          if (quo > lim) begin
            sat = 1'b1;
            val[j] = neg ? 32'h8000_0000 : 32'h7fff_ffff;
          end else begin
            val[j] = neg ? -quo[31:0] : quo[31:0];
          end
        end
      end
      res.row_index = i[1:0];
      res.inv_0 = val[0];
      res.inv_1 = val[1];
      res.inv_2 = val[2];
      res.inv_3 = val[3];
      res.singular = (det == 0);
      res.saturated = sat;
      res.last_row = (i == 3);
      inverse_q.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (row_q.size() > 0 && (calm || $urandom_range(99) >= 23)) begin
        in_valid <= 1'b1;
        in_data <= row_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (rst_n && in_valid && !in_stall) begin
      held[(rows_in % 4) * 4 + 0] = in_data.elem_0;
      held[(rows_in % 4) * 4 + 1] = in_data.elem_1;
      held[(rows_in % 4) * 4 + 2] = in_data.elem_2;
      held[(rows_in % 4) * 4 + 3] = in_data.elem_3;
      if (rows_in % 4 == 3) predict_inverse();
      rows_in <= rows_in + 1;
    end
    if (rst_n && out_valid && !out_stall) begin
      if (inverse_q.size() == 0) begin
        $display("%0t: unexpected row, expected none, actual %h", $time, out_data);
        fail_cnt++;
      end else begin
        if (out_data !== inverse_q[0]) begin
          $display("%0t: mismatch, expected %h, actual %h", $time, inverse_q[0], out_data);
          fail_cnt++;
        end
        void'(inverse_q.pop_front());
      end
      rows_out <= rows_out + 1;
    end
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall)))
      quiet_cnt <= 0;
    else
      quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt > 40000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // hold the result side once for a long stretch so the input backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && rows_out >= 24) begin
      hold_done <= 1'b1;
      hold_left <= 6000;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 23);
    end
  end

  function automatic logic [31:0] rand_elem(input int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
      default: return ($urandom_range(8) - 4) << FRAC_BITS;
    endcase
  endfunction

  task automatic push_matrix(input logic [31:0] m[16]);
    in_t r;
    for (int i = 0; i < 4; i++) begin
      r.elem_0 = m[i * 4];
      r.elem_1 = m[i * 4 + 1];
      r.elem_2 = m[i * 4 + 2];
      r.elem_3 = m[i * 4 + 3];
      row_q.push_back(r);
    end
  endtask

  initial begin
    logic [31:0] m[16];
    int mode;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (m[i]) m[i] = (i % 5 == 0) ? 32'h0001_0000 : 32'h0;
    push_matrix(m);
    foreach (m[i]) m[i] = 32'h0;
    push_matrix(m);
    foreach (m[i]) m[i] = (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
    push_matrix(m);
    foreach (m[i]) m[i] = (i % 5 == 0) ? 32'h0002_0000 : 32'h0;
    push_matrix(m);
    foreach (m[i]) m[i] = 32'h0;
    m[0] = 32'h1;
    m[5] = 32'hffff_ffff;
    m[10] = 32'h0001_0000;
    m[15] = 32'h8000_0000;
    push_matrix(m);

    // drain before the random part
    do @(posedge clk); while (row_q.size() > 0 || in_valid || inverse_q.size() > 0);

    for (int k = 0; k < 34; k++) begin
      mode = $urandom_range(2);
      foreach (m[i]) m[i] = rand_elem(mode);
      if ($urandom_range(5) == 0)
        for (int j = 0; j < 4; j++) m[12 + j] = m[4 + j];
      push_matrix(m);
    end

    do @(posedge clk); while (row_q.size() > 0 || in_valid || inverse_q.size() > 0);
    repeat (200) @(posedge clk);
    if (fail_cnt == 0 && inverse_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/mi4_pkg.sv
rtl/core/mi4_div.sv
rtl/core/matrix_inverse_4x4.sv
dv/matrix_inverse_4x4_tb.sv
